// File: rtl/core/cubic_bezier_point_eval_defines.svh
// ============================================================================
// Cubic Bezier point evaluator assertion macros
// Concurrent assertion wrappers, clocked on aclk and disabled during reset.
// ============================================================================
`ifndef CUBIC_BEZIER_POINT_EVAL_DEFINES_SVH
`define CUBIC_BEZIER_POINT_EVAL_DEFINES_SVH

`ifndef SYNTHESIS
`define CBPE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cubic bezier assertion failed");
`define CBPE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cubic bezier assertion failed");
`else
`define CBPE_ASSERT_IMPL(lbl, ante, cons)
`define CBPE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/core/cbpe_pkg.sv
// ============================================================================
// Cubic Bezier point evaluator package
// Default widths and configuration register indexes.
// ============================================================================
`timescale 1ns / 1ps

package cbpe_pkg;

    localparam int COORD_BITS_DEF  = 16;
    localparam int T_FRAC_BITS_DEF = 16;

    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_P0_X = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_P0_Y = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_P1_X = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_P1_Y = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_P2_X = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_P2_Y = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_P3_X = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_P3_Y = 3'd7;

endpackage

// File: rtl/core/cubic_bezier_point_eval.sv
// Path: an accepted parameter enters its input register, then the six multiply
// and round stages, the last driving the m_ channel. Throughput: one transaction
// per cycle unless m_ready stalls the m_ side; each stage holds one item and
// refills as soon as its contents move on. Reset: aresetn, synchronous and active
// low, clears all valid bits and sets every control point coordinate to zero.
// ============================================================================
// Cubic Bezier point evaluator
// De Casteljau evaluation of a cubic curve at parameter t, one multiply stage
// and one round stage for each interpolation level, both axes side by side.
// ============================================================================
`timescale 1ns / 1ps
`include "cubic_bezier_point_eval_defines.svh"

module cubic_bezier_point_eval #(
    parameter int COORD_BITS  = cbpe_pkg::COORD_BITS_DEF,
    parameter int T_FRAC_BITS = cbpe_pkg::T_FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [cbpe_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [COORD_BITS-1:0]           cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [T_FRAC_BITS:0]            s_t_param,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [COORD_BITS-1:0]           m_curve_x,
    output logic [COORD_BITS-1:0]           m_curve_y
);

    localparam int C  = COORD_BITS;
    localparam int T  = T_FRAC_BITS;
    localparam int PW = C + T + 3;
    localparam logic [T:0] T_ONE = {1'b1, {T{1'b0}}};
    localparam logic signed [PW-1:0] HALF = {{(PW - T){1'b0}}, 1'b1, {(T - 1){1'b0}}};

    typedef logic [C-1:0]         coord_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [C:0]    diff_t;

    coord_t ctrl_reg [2][4];

    logic [7:1] stage_en;
    logic [6:1] vld_reg;
    logic       m_valid_reg;

    logic [T:0] t1_reg, t2_reg, t3_reg, t4_reg, t5_reg;
    logic [T:0] t_sat;

    prod_t  prod1_reg [2][3];
    coord_t lv1_reg   [2][3];
    prod_t  prod2_reg [2][2];
    coord_t base2_reg [2][2];
    coord_t lv2_reg   [2][2];
    prod_t  prod3_reg [2];
    coord_t base3_reg [2];
    coord_t out_reg   [2];

    prod_t  prod1_next [2][3];
    coord_t lv1_next   [2][3];
    prod_t  prod2_next [2][2];
    coord_t lv2_next   [2][2];
    prod_t  prod3_next [2];
    coord_t out_next   [2];

    diff_t             diff1 [2][3];
    diff_t             diff2 [2][2];
    diff_t             diff3 [2];
    prod_t             rnd1  [2][3];
    prod_t             rnd2  [2][2];
    prod_t             rnd3  [2];
    logic signed [T+1:0] ts1, ts3, ts5;

    always_comb begin
        stage_en[7] = !m_valid_reg || m_ready;
        for (int k = 6; k >= 1; k--) begin
            stage_en[k] = !vld_reg[k] || stage_en[k+1];
        end
    end

    assign s_ready   = stage_en[1];
    assign m_valid   = m_valid_reg;
    assign m_curve_x = out_reg[0];
    assign m_curve_y = out_reg[1];

    assign t_sat = s_t_param[T] ? T_ONE : s_t_param;
    assign ts1   = {1'b0, t1_reg};
    assign ts3   = {1'b0, t3_reg};
    assign ts5   = {1'b0, t5_reg};

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            for (int j = 0; j < 3; j++) begin
                diff1[a][j] = $signed({1'b0, ctrl_reg[a][j+1]})
                              - $signed({1'b0, ctrl_reg[a][j]});
                prod1_next[a][j] = PW'(diff1[a][j]) * PW'(ts1);
                rnd1[a][j] = (prod1_reg[a][j] + HALF) >>> T;
                lv1_next[a][j] = ctrl_reg[a][j] + rnd1[a][j][C-1:0];
            end
            for (int j = 0; j < 2; j++) begin
                diff2[a][j] = $signed({1'b0, lv1_reg[a][j+1]})
                              - $signed({1'b0, lv1_reg[a][j]});
                prod2_next[a][j] = PW'(diff2[a][j]) * PW'(ts3);
                rnd2[a][j] = (prod2_reg[a][j] + HALF) >>> T;
                lv2_next[a][j] = base2_reg[a][j] + rnd2[a][j][C-1:0];
            end
            diff3[a] = $signed({1'b0, lv2_reg[a][1]}) - $signed({1'b0, lv2_reg[a][0]});
            prod3_next[a] = PW'(diff3[a]) * PW'(ts5);
            rnd3[a] = (prod3_reg[a] + HALF) >>> T;
            out_next[a] = base3_reg[a] + rnd3[a][C-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < 2; a++) begin
                for (int p = 0; p < 4; p++) begin
                    ctrl_reg[a][p] <= '0;
                end
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                cbpe_pkg::REG_P0_X: ctrl_reg[0][0] <= cfg_wdata;
                cbpe_pkg::REG_P0_Y: ctrl_reg[1][0] <= cfg_wdata;
                cbpe_pkg::REG_P1_X: ctrl_reg[0][1] <= cfg_wdata;
                cbpe_pkg::REG_P1_Y: ctrl_reg[1][1] <= cfg_wdata;
                cbpe_pkg::REG_P2_X: ctrl_reg[0][2] <= cfg_wdata;
                cbpe_pkg::REG_P2_Y: ctrl_reg[1][2] <= cfg_wdata;
                cbpe_pkg::REG_P3_X: ctrl_reg[0][3] <= cfg_wdata;
                cbpe_pkg::REG_P3_Y: ctrl_reg[1][3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (stage_en[1]) vld_reg[1] <= s_valid;
            for (int k = 2; k <= 6; k++) begin
                if (stage_en[k]) vld_reg[k] <= vld_reg[k-1];
            end
            if (stage_en[7]) m_valid_reg <= vld_reg[6];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            t1_reg <= t_sat;
        end
        if (stage_en[2]) begin
            t2_reg    <= t1_reg;
            prod1_reg <= prod1_next;
        end
        if (stage_en[3]) begin
            t3_reg  <= t2_reg;
            lv1_reg <= lv1_next;
        end
        if (stage_en[4]) begin
            t4_reg    <= t3_reg;
            prod2_reg <= prod2_next;
            for (int a = 0; a < 2; a++) begin
                base2_reg[a][0] <= lv1_reg[a][0];
                base2_reg[a][1] <= lv1_reg[a][1];
            end
        end
        if (stage_en[5]) begin
            t5_reg  <= t4_reg;
            lv2_reg <= lv2_next;
        end
        if (stage_en[6]) begin
            prod3_reg <= prod3_next;
            for (int a = 0; a < 2; a++) begin
                base3_reg[a] <= lv2_reg[a][0];
            end
        end
        if (stage_en[7]) begin
            out_reg <= out_next;
        end
    end

    // An accepted transaction always lands in the first stage.
    `CBPE_ASSERT_NEXT(a_accept_lands, s_valid && s_ready, vld_reg[1])
    // The saturated parameter never exceeds one.
    `CBPE_ASSERT_IMPL(a_t_saturated, vld_reg[1], t1_reg <= T_ONE)
    // A stalled last stage keeps its item until the output register frees.
    `CBPE_ASSERT_NEXT(a_last_stage_held, vld_reg[6] && !stage_en[7], vld_reg[6])
    // An empty first stage always takes new input.
    `CBPE_ASSERT_IMPL(a_ready_when_empty, !vld_reg[1], s_ready)

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Cubic Bezier point evaluator testbench
// Loads control points through the configuration port and streams curve
// parameters into the evaluator while both sides idle and stall at random.
// A short directed table covers the end points, parameters above one and
// extreme coordinates. A series of random phases with fresh control points
// follows. Every result transaction is compared with the oldest pending
// point, given by the directed table or by a local de Casteljau model.
// ============================================================================

module tb;

    localparam int COORD_BITS_DEF  = cbpe_pkg::COORD_BITS_DEF;
    localparam int T_FRAC_BITS_DEF = cbpe_pkg::T_FRAC_BITS_DEF;
    localparam int NUM_REGS        = cbpe_pkg::NUM_REGS;
    localparam int REG_IDX_W       = cbpe_pkg::REG_IDX_W;

    localparam int T_ONE       = 1 << T_FRAC_BITS_DEF;
    localparam int HOLD_CYCLES = 64;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 100;

    typedef struct packed {
        logic [COORD_BITS_DEF-1:0] x;
        logic [COORD_BITS_DEF-1:0] y;
    } curve_pt_t;

    typedef enum logic [1:0] {ROW_WRITE, ROW_CHECKED, ROW_PREDICTED} row_kind_e;

    typedef struct {
        row_kind_e                 kind;
        logic [REG_IDX_W-1:0]      idx;
        logic [COORD_BITS_DEF-1:0] wdata;
        logic [T_FRAC_BITS_DEF:0]  t;
        curve_pt_t                 pt;
    } stim_row_t;

    logic                        aclk      = 1'b0;
    logic                        aresetn   = 1'b0;
    logic                        cfg_wr_en = 1'b0;
    logic [REG_IDX_W-1:0]        cfg_index = '0;
    logic [COORD_BITS_DEF-1:0]   cfg_wdata = '0;
    logic                        s_valid   = 1'b0;
    logic                        s_ready;
    logic [T_FRAC_BITS_DEF:0]    s_t_param = '0;
    logic                        m_valid;
    logic                        m_ready   = 1'b0;
    logic [COORD_BITS_DEF-1:0]   m_curve_x;
    logic [COORD_BITS_DEF-1:0]   m_curve_y;

    logic [COORD_BITS_DEF-1:0]   ctrl_pt [NUM_REGS];
    curve_pt_t                   curve_pts_due [$];
    stim_row_t                   dir_rows [$];
    logic [T_FRAC_BITS_DEF:0]    corner_t [6];
    int                          mismatch_count = 0;
    int                          quiet_cycles   = 0;
    int                          tx_idle_pct    = 0;
    int                          rx_stall_pct   = 0;
    bit                          hold_req       = 1'b0;

    cubic_bezier_point_eval dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_t_param (s_t_param),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_curve_x (m_curve_x),
        .m_curve_y (m_curve_y)
    );

    always #1 aclk = ~aclk;

    function automatic logic [COORD_BITS_DEF-1:0] blend(input logic [COORD_BITS_DEF-1:0] a,
                                                        input logic [COORD_BITS_DEF-1:0] b,
                                                        input logic [T_FRAC_BITS_DEF:0] t);
        logic [63:0] acc;
        acc = 64'(a) * (64'(T_ONE) - 64'(t)) + 64'(b) * 64'(t) + 64'(T_ONE / 2);
        return acc[T_FRAC_BITS_DEF +: COORD_BITS_DEF];
    endfunction

    function automatic logic [COORD_BITS_DEF-1:0] curve_coord(input logic [COORD_BITS_DEF-1:0] a,
                                                              input logic [COORD_BITS_DEF-1:0] b,
                                                              input logic [COORD_BITS_DEF-1:0] c,
                                                              input logic [COORD_BITS_DEF-1:0] d,
                                                              input logic [T_FRAC_BITS_DEF:0] t);
        logic [COORD_BITS_DEF-1:0] ab, bc, cd;
        ab = blend(a, b, t);
        bc = blend(b, c, t);
        cd = blend(c, d, t);
        return blend(blend(ab, bc, t), blend(bc, cd, t), t);
    endfunction

    function automatic curve_pt_t bezier_point(input logic [T_FRAC_BITS_DEF:0] t_raw);
        logic [T_FRAC_BITS_DEF:0] t;
        curve_pt_t                pt;
        t    = (t_raw > T_ONE) ? (T_FRAC_BITS_DEF + 1)'(T_ONE) : t_raw;
        pt.x = curve_coord(ctrl_pt[cbpe_pkg::REG_P0_X], ctrl_pt[cbpe_pkg::REG_P1_X],
                           ctrl_pt[cbpe_pkg::REG_P2_X], ctrl_pt[cbpe_pkg::REG_P3_X], t);
        pt.y = curve_coord(ctrl_pt[cbpe_pkg::REG_P0_Y], ctrl_pt[cbpe_pkg::REG_P1_Y],
                           ctrl_pt[cbpe_pkg::REG_P2_Y], ctrl_pt[cbpe_pkg::REG_P3_Y], t);
        return pt;
    endfunction

    function automatic logic [T_FRAC_BITS_DEF:0] pick_param();
        case ($urandom_range(0, 9))
            0:       return corner_t[$urandom_range(0, 5)];
            1, 2:    return (T_FRAC_BITS_DEF + 1)'($urandom_range(T_ONE + 1, 2 * T_ONE - 1));
            default: return (T_FRAC_BITS_DEF + 1)'($urandom_range(0, T_ONE));
        endcase
    endfunction

    task automatic add_row(input row_kind_e kind,
                           input logic [REG_IDX_W-1:0] idx,
                           input logic [COORD_BITS_DEF-1:0] wdata,
                           input logic [T_FRAC_BITS_DEF:0] t,
                           input logic [COORD_BITS_DEF-1:0] ex,
                           input logic [COORD_BITS_DEF-1:0] ey);
        stim_row_t r;
        r.kind   = kind;
        r.idx    = idx;
        r.wdata  = wdata;
        r.t      = t;
        r.pt.x   = ex;
        r.pt.y   = ey;
        dir_rows = {dir_rows, r};
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                             input logic [COORD_BITS_DEF-1:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wdata   <= value;
        ctrl_pt[idx] = value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_param(input logic [T_FRAC_BITS_DEF:0] t, input bit typed,
                              input curve_pt_t typed_pt);
        int        gap;
        curve_pt_t due_pt;
        @(negedge aclk);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 7);
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_t_param <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        due_pt        = typed ? typed_pt : bezier_point(t);
        curve_pts_due = {curve_pts_due, due_pt};
    endtask

    // Results only leave the block when the sink is ready, so an empty
    // queue of pending points means the pipeline is empty as well.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (curve_pts_due.size() != 0) @(posedge aclk);
    endtask

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_req = 1'b0;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
                m_ready   <= 1'b0;
                stall_left = $urandom_range(1, 7) - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : result_check
        curve_pt_t due;
        if (aresetn && m_valid && m_ready) begin
            if (curve_pts_due.size() == 0) begin
                $error("unexpected transaction: curve_x %0d curve_y %0d", m_curve_x, m_curve_y);
                mismatch_count++;
            end else begin
                due = curve_pts_due.pop_front();
                if (m_curve_x !== due.x) begin
                    $error("curve_x: expected %0d, actual %0d", due.x, m_curve_x);
                    mismatch_count++;
                end
                if (m_curve_y !== due.y) begin
                    $error("curve_y: expected %0d, actual %0d", due.y, m_curve_y);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $error("timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [COORD_BITS_DEF-1:0] value;
        foreach (ctrl_pt[i]) ctrl_pt[i] = '0;
        corner_t = '{17'h00000, 17'h00001, 17'h0FFFF, 17'h10000, 17'h10001, 17'h1FFFF};

        // After reset every control point sits at the origin.
        add_row(ROW_CHECKED, cbpe_pkg::REG_P0_X, '0, 17'h00000, 16'h0000, 16'h0000);
        add_row(ROW_CHECKED, cbpe_pkg::REG_P0_X, '0, 17'h00001, 16'h0000, 16'h0000);
        add_row(ROW_CHECKED, cbpe_pkg::REG_P0_X, '0, 17'h08000, 16'h0000, 16'h0000);
        add_row(ROW_CHECKED, cbpe_pkg::REG_P0_X, '0, 17'h0FFFF, 16'h0000, 16'h0000);
        add_row(ROW_CHECKED, cbpe_pkg::REG_P0_X, '0, 17'h10000, 16'h0000, 16'h0000);
        add_row(ROW_CHECKED, cbpe_pkg::REG_P0_X, '0, 17'h1FFFF, 16'h0000, 16'h0000);
        // All points at the top of the range.
        for (int r = 0; r < NUM_REGS; r++)
            add_row(ROW_WRITE, REG_IDX_W'(r), 16'hFFFF, '0, '0, '0);
        add_row(ROW_CHECKED, cbpe_pkg::REG_P0_X, '0, 17'h00000, 16'hFFFF, 16'hFFFF);
        add_row(ROW_CHECKED, cbpe_pkg::REG_P0_X, '0, 17'h08000, 16'hFFFF, 16'hFFFF);
        add_row(ROW_CHECKED, cbpe_pkg::REG_P0_X, '0, 17'h1FFFF, 16'hFFFF, 16'hFFFF);
        // A curve from one corner to the other; the end points are exact.
        add_row(ROW_WRITE, cbpe_pkg::REG_P0_X, 16'h0000, '0, '0, '0);
        add_row(ROW_WRITE, cbpe_pkg::REG_P0_Y, 16'hFFFF, '0, '0, '0);
        add_row(ROW_WRITE, cbpe_pkg::REG_P1_X, 16'h1234, '0, '0, '0);
        add_row(ROW_WRITE, cbpe_pkg::REG_P1_Y, 16'hFEDC, '0, '0, '0);
        add_row(ROW_WRITE, cbpe_pkg::REG_P2_X, 16'hABCD, '0, '0, '0);
        add_row(ROW_WRITE, cbpe_pkg::REG_P2_Y, 16'h0F0F, '0, '0, '0);
        add_row(ROW_WRITE, cbpe_pkg::REG_P3_X, 16'hFFFF, '0, '0, '0);
        add_row(ROW_WRITE, cbpe_pkg::REG_P3_Y, 16'h0000, '0, '0, '0);
        add_row(ROW_CHECKED, cbpe_pkg::REG_P0_X, '0, 17'h00000, 16'h0000, 16'hFFFF);
        add_row(ROW_CHECKED, cbpe_pkg::REG_P0_X, '0, 17'h10000, 16'hFFFF, 16'h0000);
        add_row(ROW_CHECKED, cbpe_pkg::REG_P0_X, '0, 17'h10001, 16'hFFFF, 16'h0000);
        add_row(ROW_CHECKED, cbpe_pkg::REG_P0_X, '0, 17'h1FFFF, 16'hFFFF, 16'h0000);
        add_row(ROW_PREDICTED, cbpe_pkg::REG_P0_X, '0, 17'h00001, '0, '0);
        add_row(ROW_PREDICTED, cbpe_pkg::REG_P0_X, '0, 17'h04000, '0, '0);
        add_row(ROW_PREDICTED, cbpe_pkg::REG_P0_X, '0, 17'h08000, '0, '0);
        add_row(ROW_PREDICTED, cbpe_pkg::REG_P0_X, '0, 17'h0C000, '0, '0);
        add_row(ROW_PREDICTED, cbpe_pkg::REG_P0_X, '0, 17'h0FFFF, '0, '0);
        add_row(ROW_PREDICTED, cbpe_pkg::REG_P0_X, '0, 17'h0AAAA, '0, '0);
        add_row(ROW_PREDICTED, cbpe_pkg::REG_P0_X, '0, 17'h15555, '0, '0);

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct  = 20;
        rx_stall_pct = 20;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_WRITE) begin
                drain_results();
                write_reg(dir_rows[i].idx, dir_rows[i].wdata);
            end else begin
                send_param(dir_rows[i].t, dir_rows[i].kind == ROW_CHECKED, dir_rows[i].pt);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            for (int r = 0; r < NUM_REGS; r++) begin
                case (phase)
                    1:       value = '0;
                    2:       value = '1;
                    4:       value = $urandom_range(0, 1) ? '1 : '0;
                    default: value = COORD_BITS_DEF'($urandom_range(0, 65535));
                endcase
                write_reg(REG_IDX_W'(r), value);
            end
            tx_idle_pct  = (phase == PHASES - 1 || phase % 3 == 0) ? 0 : 30;
            rx_stall_pct = (phase == PHASES - 1 || phase % 3 == 1) ? 0 : 30;
            // The sink stops for a long stretch while the source keeps offering.
            if (phase == 3) hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_param(pick_param(), 1'b0, '0);
        end

        drain_results();
        repeat (16) @(posedge aclk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
